// ----- rtl/cbge_pkg.sv -----
// shared types, constants and microprogram of the cascaded biquad equalizer
package cbge_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 20;
	localparam int SLOTS    = 5;
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	// five products per section fit in two extra bits
	localparam int ACC_W    = PROD_W + 2;
	localparam int STEP_W   = 4;

	// saturation bounds, in sample width and accumulator width
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
	localparam logic signed [ACC_W-1:0]    ACC_SAT_HI = ACC_W'(32'sd32767);
	localparam logic signed [ACC_W-1:0]    ACC_SAT_LO = ACC_W'(-32'sd32768);

	// item operation codes
	typedef enum logic {
		OP_FILTER = 1'b0,
		OP_COEFF  = 1'b1
	} op_t;

	// coefficient slots within a section
	typedef enum logic [2:0] {
		SLOT_B0 = 3'd0,
		SLOT_B1 = 3'd1,
		SLOT_B2 = 3'd2,
		SLOT_A1 = 3'd3,
		SLOT_A2 = 3'd4
	} slot_t;

	// multiplier data operand source
	typedef enum logic [2:0] {
		OPND_X0 = 3'd0,
		OPND_X1 = 3'd1,
		OPND_X2 = 3'd2,
		OPND_Y1 = 3'd3,
		OPND_Y2 = 3'd4
	} opnd_t;

	// one control word of the microprogram
	typedef struct packed {
		logic  issue;  // start one multiply-accumulate
		logic  first;  // load the accumulator instead of adding
		logic  sub;    // subtract the product
		opnd_t src;
		slot_t slot;
		logic  fin;    // round, saturate and shift the section history
		logic  loop;   // back to entry while sections remain
		logic  emit;   // hand the item to the output register
	} uword_t;

	// control from sequencer to datapath
	typedef struct packed {
		logic  start;
		logic  issue;
		logic  first;
		logic  sub;
		opnd_t src;
		slot_t slot;
		logic  fin;
	} dp_ctl_t;

	localparam logic [STEP_W-1:0] STEP_ENTRY = '0;

	// microprogram: feedforward history first, then feedback, then the new input
	function automatic uword_t ucode(logic [STEP_W-1:0] step);
		uword_t w;
		w = '0;
		case (step)
			4'd0: begin
				w.issue = 1'b1;
				w.first = 1'b1;
				w.src   = OPND_X1;
				w.slot  = SLOT_B1;
			end
			4'd1: begin
				w.issue = 1'b1;
				w.src   = OPND_X2;
				w.slot  = SLOT_B2;
			end
			4'd2: begin
				w.issue = 1'b1;
				w.sub   = 1'b1;
				w.src   = OPND_Y1;
				w.slot  = SLOT_A1;
			end
			4'd3: begin
				w.issue = 1'b1;
				w.sub   = 1'b1;
				w.src   = OPND_Y2;
				w.slot  = SLOT_A2;
			end
			4'd4: begin
				w.issue = 1'b1;
				w.src   = OPND_X0;
				w.slot  = SLOT_B0;
			end
			// steps five and six drain the multiplier pipeline
			4'd5: w = '0;
			4'd6: w = '0;
			4'd7: begin
				w.fin  = 1'b1;
				w.loop = 1'b1;
			end
			4'd8: w.emit = 1'b1;
			default: w.emit = 1'b1;
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/cbge_datapath.sv -----
// coefficient memory, multiply-accumulate pipeline, rounding and section history
module cbge_datapath #(
	parameter int NUM_SECTIONS    = 7,
	parameter int COEFF_FRAC_BITS = 16,
	localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  cbge_pkg::dp_ctl_t                         ctl,
	input  logic [SEC_W-1:0]                          sec,
	input  logic signed [cbge_pkg::SAMPLE_W-1:0]      sample_in,
	input  logic                                      coeff_wr,
	input  logic [2:0]                                band_select,
	input  logic [2:0]                                coeff_select,
	input  logic signed [cbge_pkg::COEF_W-1:0]        coeff_value,
	output logic signed [cbge_pkg::SAMPLE_W-1:0]      y_out,
	output logic                                      sat_out
);

	localparam int DEPTH  = NUM_SECTIONS * cbge_pkg::SLOTS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SW     = cbge_pkg::SAMPLE_W;
	localparam int CW     = cbge_pkg::COEF_W;
	localparam int PW     = cbge_pkg::PROD_W;
	localparam int AW     = cbge_pkg::ACC_W;
	localparam logic [AW-1:0] ROUND_BIAS = (AW'(1) << COEFF_FRAC_BITS) - AW'(1);

	logic signed [CW-1:0] coeff_mem [DEPTH];
	logic [DEPTH-1:0]     coeff_vld_q;

	logic [7:0]        wr_lin;
	logic [7:0]        rd_lin;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;

	logic signed [SW-1:0] x0_q;
	logic signed [SW-1:0] x1_q [NUM_SECTIONS];
	logic signed [SW-1:0] x2_q [NUM_SECTIONS];
	logic signed [SW-1:0] y1_q [NUM_SECTIONS];
	logic signed [SW-1:0] y2_q [NUM_SECTIONS];
	logic                 sat_q;

	logic signed [SW-1:0] opnd;
	logic signed [SW-1:0] opnd_s1;
	logic signed [CW-1:0] coeff_s1;
	logic                 cvld_s1;
	logic                 vld_s1;
	logic                 first_s1;
	logic                 sub_s1;
	logic signed [CW-1:0] coeff_eff;
	logic signed [PW-1:0] prod_s2;
	logic                 vld_s2;
	logic                 first_s2;
	logic                 sub_s2;
	logic signed [AW-1:0] prod_ext;
	logic signed [AW-1:0] addend;
	logic signed [AW-1:0] acc_q;

	logic signed [AW-1:0] acc_biased;
	logic signed [AW-1:0] quo;
	logic                 over_hi;
	logic                 over_lo;
	logic signed [SW-1:0] y_sat;

	// coefficient addressing: section * 5 + slot
	assign wr_lin  = {5'b0, band_select} * 8'(cbge_pkg::SLOTS) + {5'b0, coeff_select};
	assign rd_lin  = 8'(sec) * 8'(cbge_pkg::SLOTS) + 8'(ctl.slot);
	assign wr_addr = wr_lin[ADDR_W-1:0];
	assign rd_addr = rd_lin[ADDR_W-1:0];
	assign wr_en   = coeff_wr && ({29'b0, band_select} < 32'(NUM_SECTIONS))
		&& (coeff_select < 3'(cbge_pkg::SLOTS));

	// coefficient memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			coeff_mem[wr_addr] <= coeff_value;
		end
		if (ctl.issue) begin
			coeff_s1 <= coeff_mem[rd_addr];
		end
	end

	// written-entry flags, an unwritten coefficient reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_vld_q <= '0;
			cvld_s1     <= 1'b0;
		end else begin
			if (wr_en) begin
				coeff_vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.issue) begin
				cvld_s1 <= coeff_vld_q[rd_addr];
			end
		end
	end

	// operand select
	always_comb begin
		case (ctl.src)
			cbge_pkg::OPND_X0: opnd = x0_q;
			cbge_pkg::OPND_X1: opnd = x1_q[sec];
			cbge_pkg::OPND_X2: opnd = x2_q[sec];
			cbge_pkg::OPND_Y1: opnd = y1_q[sec];
			cbge_pkg::OPND_Y2: opnd = y2_q[sec];
			default:           opnd = x0_q;
		endcase
	end

	// issue stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			sub_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			first_s2 <= 1'b0;
			sub_s2   <= 1'b0;
		end else begin
			vld_s1   <= ctl.issue;
			first_s1 <= ctl.first;
			sub_s1   <= ctl.sub;
			vld_s2   <= vld_s1;
			first_s2 <= first_s1;
			sub_s2   <= sub_s1;
		end
	end

	// multiply stage
	assign coeff_eff = cvld_s1 ? coeff_s1 : '0;

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			opnd_s1 <= opnd;
		end
		if (vld_s1) begin
			prod_s2 <= coeff_eff * opnd_s1;
		end
	end

	// accumulate stage
	assign prod_ext = {{(AW - PW){prod_s2[PW-1]}}, prod_s2};
	assign addend   = sub_s2 ? -prod_ext : prod_ext;

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + addend;
		end
	end

	// truncate toward zero, then clamp to the sample range
	assign acc_biased = acc_q + (acc_q[AW-1] ? $signed(ROUND_BIAS) : '0);
	assign quo        = acc_biased >>> COEFF_FRAC_BITS;
	assign over_hi    = quo > cbge_pkg::ACC_SAT_HI;
	assign over_lo    = quo < cbge_pkg::ACC_SAT_LO;
	assign y_sat      = over_hi ? cbge_pkg::SAMPLE_MAX :
		(over_lo ? cbge_pkg::SAMPLE_MIN : quo[SW-1:0]);

	// section history and running sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q  <= '0;
			sat_q <= 1'b0;
			for (int i = 0; i < NUM_SECTIONS; i++) begin
				x1_q[i] <= '0;
				x2_q[i] <= '0;
				y1_q[i] <= '0;
				y2_q[i] <= '0;
			end
		end else if (ctl.start) begin
			x0_q  <= sample_in;
			sat_q <= 1'b0;
		end else if (ctl.fin) begin
			x1_q[sec] <= x0_q;
			x2_q[sec] <= x1_q[sec];
			y1_q[sec] <= y_sat;
			y2_q[sec] <= y1_q[sec];
			x0_q      <= y_sat;
			sat_q     <= sat_q | over_hi | over_lo;
		end
	end

	assign y_out   = x0_q;
	assign sat_out = sat_q;

endmodule

// ----- rtl/cascaded_biquad_graphic_equalizer.sv -----
// Cascaded biquad graphic equalizer: seven Direct Form I sections on one
// multiply-accumulate unit under a microcoded sequencer.
// Input channel (item_valid / item_stall): operation 0 filters sample_in,
// operation 1 writes coeff_value (Q3.16) into slot coeff_select of section
// band_select; writes to a missing section or slot are dropped.
// A coefficient write gives no result; writes can arrive
// back to back while no sample is in flight.
// A sample runs each section in turn (five products through a three-stage
// multiply pipeline, then round and saturate) and then one emit step.
// item_stall stays high from the accept until the emit step hands the result
// on, so the next sample is taken only after the previous one has left; the
// single multiplier and the one section result feeding the next section
// allow only one sample in flight.
// Output channel (result_valid / result_stall): sample_out from the last
// section and clipped when any section saturated. A waiting result does not
// block the input; a finished sample holds in its emit step while the output
// register is still full and stalled.
// Reset marks every coefficient unwritten, so each reads as zero, and clears the section history and the handshakes.
module cascaded_biquad_graphic_equalizer #(
	parameter int NUM_SECTIONS    = 7,
	parameter int COEFF_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 operation,
	input  logic signed [cbge_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [2:0]                           band_select,
	input  logic [2:0]                           coeff_select,
	input  logic signed [cbge_pkg::COEF_W-1:0]   coeff_value,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [cbge_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                 clipped
);

	localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

	logic                                 busy_q;
	logic [cbge_pkg::STEP_W-1:0]          step_q;
	logic [SEC_W-1:0]                     sec_q;
	logic                                 result_valid_q;
	logic signed [cbge_pkg::SAMPLE_W-1:0] sample_out_q;
	logic                                 clipped_q;

	cbge_pkg::uword_t                     uw;
	cbge_pkg::dp_ctl_t                    ctl;
	logic                                 accept;
	logic                                 is_filter;
	logic                                 last_sec;
	logic                                 out_free;
	logic                                 emit_go;
	logic signed [cbge_pkg::SAMPLE_W-1:0] y_dp;
	logic                                 sat_dp;

	// handshake and decode
	assign item_stall = busy_q;
	assign accept     = item_valid && !item_stall;
	assign is_filter  = (operation == cbge_pkg::OP_FILTER);
	assign uw         = cbge_pkg::ucode(step_q);
	assign last_sec   = (sec_q == SEC_W'(NUM_SECTIONS - 1));
	assign out_free   = !result_valid_q || !result_stall;
	assign emit_go    = busy_q && uw.emit && out_free;

	// datapath control from the current control word
	always_comb begin
		ctl       = '0;
		ctl.start = accept && is_filter;
		ctl.issue = busy_q && uw.issue;
		ctl.first = uw.first;
		ctl.sub   = uw.sub;
		ctl.src   = uw.src;
		ctl.slot  = uw.slot;
		ctl.fin   = busy_q && uw.fin;
	end

	cbge_datapath #(
		.NUM_SECTIONS    (NUM_SECTIONS),
		.COEFF_FRAC_BITS (COEFF_FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sec          (sec_q),
		.sample_in    (sample_in),
		.coeff_wr     (accept && !is_filter),
		.band_select  (band_select),
		.coeff_select (coeff_select),
		.coeff_value  (coeff_value),
		.y_out        (y_dp),
		.sat_out      (sat_dp)
	);

	// step counter, section counter and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			step_q         <= cbge_pkg::STEP_ENTRY;
			sec_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				if (accept && is_filter) begin
					busy_q <= 1'b1;
					step_q <= cbge_pkg::STEP_ENTRY;
					sec_q  <= '0;
				end
			end else if (uw.emit) begin
				if (out_free) begin
					busy_q <= 1'b0;
				end
			end else if (uw.loop && !last_sec) begin
				step_q <= cbge_pkg::STEP_ENTRY;
				sec_q  <= sec_q + 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit_go) begin
			sample_out_q <= y_dp;
			clipped_q    <= sat_dp;
		end
	end

	assign result_valid = result_valid_q;
	assign sample_out   = sample_out_q;
	assign clipped      = clipped_q;

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the cascaded biquad equalizer: random stimulus, in-order checking
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSEC      = 7;
	localparam int COEF_FRAC = 16;
	localparam int UNITY     = 1 << COEF_FRAC;
	localparam int COEF_MAX  = (1 << (cbge_pkg::COEF_W - 1)) - 1;
	localparam int COEF_MIN  = -(1 << (cbge_pkg::COEF_W - 1));
	localparam int S_MAX     = 32767;
	localparam int S_MIN     = -32768;
	localparam int ITEM_GOAL = 1300;
	localparam int TAIL_LEN  = 120;
	localparam int DRAIN     = 80;
	localparam int LIMIT     = 2000;

	typedef struct {
		cbge_pkg::op_t                        op;
		logic signed [cbge_pkg::SAMPLE_W-1:0] smp;
		logic [2:0]                           band;
		logic [2:0]                           slot;
		logic signed [cbge_pkg::COEF_W-1:0]   coef;
	} eq_item_t;

	typedef struct {
		logic signed [cbge_pkg::SAMPLE_W-1:0] smp;
		logic                                 clip;
	} eq_out_t;

	logic                                 clk;
	logic                                 arst_n       = 1'b0;
	logic                                 item_valid   = 1'b0;
	logic                                 item_stall;
	logic                                 operation    = cbge_pkg::OP_FILTER;
	logic signed [cbge_pkg::SAMPLE_W-1:0] sample_in    = '0;
	logic [2:0]                           band_select  = '0;
	logic [2:0]                           coeff_select = '0;
	logic signed [cbge_pkg::COEF_W-1:0]   coeff_value  = '0;
	logic                                 result_valid;
	logic                                 result_stall = 1'b0;
	logic signed [cbge_pkg::SAMPLE_W-1:0] sample_out;
	logic                                 clipped;

	// predictor state: coefficients and per-section history
	logic signed [cbge_pkg::COEF_W-1:0]   eq_coef [NSEC*cbge_pkg::SLOTS];
	logic signed [cbge_pkg::SAMPLE_W-1:0] eq_xh   [NSEC*2];
	logic signed [cbge_pkg::SAMPLE_W-1:0] eq_yh   [NSEC*2];

	eq_item_t pending[$];
	eq_out_t  awaited[$];
	int       queued_items = 0;
	int       sent_items   = 0;
	int       useful_items = 0;
	int       mismatches   = 0;
	int       in_gap;
	int       out_gap;
	int       quiet_cycles;
	int       phase_left;
	logic     idle_on;
	logic     tail_phase   = 1'b0;

	cascaded_biquad_graphic_equalizer #(
		.NUM_SECTIONS   (NSEC),
		.COEFF_FRAC_BITS(COEF_FRAC)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.operation   (operation),
		.sample_in   (sample_in),
		.band_select (band_select),
		.coeff_select(coeff_select),
		.coeff_value (coeff_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sample_out  (sample_out),
		.clipped     (clipped)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run one accepted item through the predicted filter chain
	function automatic void equalize_item(cbge_pkg::op_t op,
			logic signed [cbge_pkg::SAMPLE_W-1:0] smp, logic [2:0] band,
			logic [2:0] slot, logic signed [cbge_pkg::COEF_W-1:0] coef);
		logic signed [cbge_pkg::SAMPLE_W-1:0] v;
		logic signed [cbge_pkg::SAMPLE_W-1:0] y;
		logic                                 sat;
		longint                               acc;
		longint                               q;
		int                                   c;
		eq_out_t                              r;
		if (op == cbge_pkg::OP_COEFF) begin
			if (band < NSEC && slot < cbge_pkg::SLOTS)
				eq_coef[band * cbge_pkg::SLOTS + slot] = coef;
			return;
		end
		v   = smp;
		sat = 1'b0;
		for (int s = 0; s < NSEC; s++) begin
			c   = s * cbge_pkg::SLOTS;
			acc = longint'(eq_coef[c + cbge_pkg::SLOT_B0]) * longint'(v)
				+ longint'(eq_coef[c + cbge_pkg::SLOT_B1]) * longint'(eq_xh[2*s])
				+ longint'(eq_coef[c + cbge_pkg::SLOT_B2]) * longint'(eq_xh[2*s+1])
				- longint'(eq_coef[c + cbge_pkg::SLOT_A1]) * longint'(eq_yh[2*s])
				- longint'(eq_coef[c + cbge_pkg::SLOT_A2]) * longint'(eq_yh[2*s+1]);
			// drop the fraction bits, rounding toward zero
			if (acc < 0)
				q = -((-acc) >>> COEF_FRAC);
			else
				q = acc >>> COEF_FRAC;
			if (q > longint'(S_MAX)) begin
				y   = cbge_pkg::SAMPLE_MAX;
				sat = 1'b1;
			end else if (q < longint'(S_MIN)) begin
				y   = cbge_pkg::SAMPLE_MIN;
				sat = 1'b1;
			end else begin
				y = cbge_pkg::SAMPLE_W'(q);
			end
			eq_xh[2*s+1] = eq_xh[2*s];
			eq_xh[2*s]   = v;
			eq_yh[2*s+1] = eq_yh[2*s];
			eq_yh[2*s]   = y;
			v = y;
		end
		r.smp  = v;
		r.clip = sat;
		awaited.push_back(r);
	endfunction

	function automatic int rand_between(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// filter item, coefficient fields carry noise
	function automatic void queue_sample(int smp);
		eq_item_t it;
		it.op   = cbge_pkg::OP_FILTER;
		it.smp  = cbge_pkg::SAMPLE_W'(smp);
		it.band = 3'($urandom());
		it.slot = 3'($urandom());
		it.coef = cbge_pkg::COEF_W'($urandom());
		pending.push_back(it);
		queued_items++;
		useful_items++;
	endfunction

	// coefficient write item, sample field carries noise
	function automatic void queue_write(int band, int slot, int coef);
		eq_item_t it;
		it.op   = cbge_pkg::OP_COEFF;
		it.smp  = cbge_pkg::SAMPLE_W'($urandom());
		it.band = 3'(band);
		it.slot = 3'(slot);
		it.coef = cbge_pkg::COEF_W'(coef);
		pending.push_back(it);
		queued_items++;
		if (band < NSEC && slot < cbge_pkg::SLOTS)
			useful_items++;
	endfunction

	function automatic int rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return rand_between(-8192, 8192);
		else if (r < 9)
			return rand_between(S_MIN, S_MAX);
		else
			return $urandom_range(0, 1) ? S_MAX : S_MIN;
	endfunction

	function automatic int full_coef();
		return rand_between(COEF_MIN, COEF_MAX);
	endfunction

	// roughly stable section around unity gain
	function automatic int mild_coef(cbge_pkg::slot_t slot);
		case (slot)
			cbge_pkg::SLOT_B0: return UNITY + rand_between(-16384, 16384);
			cbge_pkg::SLOT_A1: return rand_between(-49152, 49152);
			default:           return rand_between(-32768, 32768);
		endcase
	endfunction

	// stimulus, reset and end of run
	initial begin : stimulus
		int r;
		int s;
		int kind;
		for (int i = 0; i < NSEC*cbge_pkg::SLOTS; i++)
			eq_coef[i] = '0;
		for (int i = 0; i < NSEC*2; i++) begin
			eq_xh[i] = '0;
			eq_yh[i] = '0;
		end

		// zero coefficients after reset give silence
		queue_sample(S_MAX);
		queue_sample(S_MIN);
		// writes to a missing section or slot are dropped
		queue_write(NSEC, cbge_pkg::SLOT_B0, COEF_MAX);
		queue_write(0, cbge_pkg::SLOTS, UNITY);
		queue_write(2, 7, COEF_MIN);
		// unity chain passes samples through
		for (int i = 0; i < NSEC; i++)
			queue_write(i, cbge_pkg::SLOT_B0, UNITY);
		queue_sample(S_MAX);
		queue_sample(S_MIN);
		queue_sample(-1);
		// largest gain saturates both ways, small negatives truncate toward zero
		queue_write(0, cbge_pkg::SLOT_B0, COEF_MAX);
		queue_sample(S_MAX);
		queue_sample(S_MIN);
		queue_sample(-1);
		queue_write(3, cbge_pkg::SLOT_B0, COEF_MIN);
		queue_sample(-3);
		// feedback and feedforward history in one section
		queue_write(5, cbge_pkg::SLOT_A1, -32768);
		queue_write(5, cbge_pkg::SLOT_A2, 16384);
		queue_write(5, cbge_pkg::SLOT_B1, 32768);
		queue_write(5, cbge_pkg::SLOT_B2, -32768);
		queue_sample(1000);
		queue_sample(-1000);

		// random rounds, mostly coefficient sets followed by sample bursts
		while (useful_items < ITEM_GOAL) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				repeat (rand_between(1, NSEC)) begin
					s    = $urandom_range(0, NSEC - 1);
					kind = $urandom_range(0, 9);
					for (int k = 0; k < cbge_pkg::SLOTS; k++) begin
						if (kind < 8)
							queue_write(s, k, mild_coef(cbge_pkg::slot_t'(k)));
						else if (kind == 8)
							queue_write(s, k, full_coef());
						else
							queue_write(s, k, (k == cbge_pkg::SLOT_B0) ? UNITY : 0);
					end
				end
				repeat (rand_between(5, 30))
					queue_sample(rand_sample());
			end else if (r < 70) begin
				repeat (rand_between(1, 4))
					queue_write($urandom_range(0, NSEC - 1),
						$urandom_range(0, cbge_pkg::SLOTS - 1), full_coef());
				repeat (rand_between(1, 5))
					queue_sample(rand_sample());
			end else if (r < 85) begin
				repeat (rand_between(3, 15))
					queue_sample($urandom_range(0, 3) == 0 ?
						($urandom_range(0, 1) ? S_MAX : S_MIN) : rand_between(S_MIN, S_MAX));
			end else begin
				repeat (rand_between(1, 3)) begin
					if ($urandom_range(0, 1))
						queue_write(rand_between(NSEC, 7), $urandom_range(0, 7), full_coef());
					else
						queue_write($urandom_range(0, 7), rand_between(cbge_pkg::SLOTS, 7),
							full_coef());
					queue_sample(rand_sample());
				end
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_items < queued_items)
			@(posedge clk);
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && awaited.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// switch between stretches with and without idling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_on    <= 1'b1;
			phase_left <= 200;
		end else if (phase_left == 0) begin
			idle_on    <= ($urandom_range(0, 3) != 0);
			phase_left <= $urandom_range(50, 400);
		end else begin
			phase_left <= phase_left - 1;
		end
	end

	// item driver
	always @(posedge clk or negedge arst_n) begin : drive_items
		eq_item_t nxt;
		if (!arst_n) begin
			item_valid   <= 1'b0;
			operation    <= cbge_pkg::OP_FILTER;
			sample_in    <= '0;
			band_select  <= '0;
			coeff_select <= '0;
			coeff_value  <= '0;
			in_gap       <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				equalize_item(cbge_pkg::op_t'(operation), sample_in, band_select,
					coeff_select, coeff_value);
				sent_items++;
			end
			// a stalled item holds its payload
			if (!(item_valid && item_stall)) begin
				if (in_gap != 0) begin
					in_gap     <= in_gap - 1;
					item_valid <= 1'b0;
				end else if (pending.size() == 0) begin
					item_valid <= 1'b0;
				end else if (idle_on && !tail_phase && $urandom_range(0, 5) == 0) begin
					in_gap     <= $urandom_range(0, 8);
					item_valid <= 1'b0;
				end else begin
					nxt          = pending.pop_front();
					item_valid   <= 1'b1;
					operation    <= nxt.op;
					sample_in    <= nxt.smp;
					band_select  <= nxt.band;
					coeff_select <= nxt.slot;
					coeff_value  <= nxt.coef;
				end
			end
			tail_phase <= (pending.size() <= TAIL_LEN);
		end
	end

	// compare one result with the oldest prediction
	task automatic check_sample(logic signed [cbge_pkg::SAMPLE_W-1:0] smp, logic clip);
		eq_out_t e;
		if (awaited.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: sample_out %0d clipped %0b", smp, clip);
		end else begin
			e = awaited.pop_front();
			if (smp !== e.smp || clip !== e.clip) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: sample_out exp %0d got %0d, clipped exp %0b got %0b",
						e.smp, smp, e.clip, clip);
			end
		end
	endtask

	// result monitor, output stall and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			out_gap      <= 0;
			quiet_cycles <= 0;
		end else begin
			if (result_valid && !result_stall)
				check_sample(sample_out, clipped);
			// stall bursts, each new one starting only after result_stall has been low
			if (out_gap != 0) begin
				out_gap      <= out_gap - 1;
				result_stall <= 1'b1;
			end else if (!result_stall && idle_on && !tail_phase &&
					$urandom_range(0, 5) == 0) begin
				out_gap      <= $urandom_range(0, 8);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
			// cycles with no item moving on either channel
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
